>>> rtl/core/lob_pkg.sv
// Shared types, sizes and codes of the limit order book engine.
`default_nettype none
package lob_pkg;

  localparam int ORDER_SLOTS = 64;
  localparam int LEVEL_SLOTS = 64;
  localparam int OIDX_W = $clog2(ORDER_SLOTS);
  localparam int LIDX_W = $clog2(LEVEL_SLOTS);
  localparam int HELD_W = $clog2(ORDER_SLOTS + 1);
  localparam int SCAN_W = $clog2(((ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS) + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MODIFY = 2'd2,
    OP_LOOKUP = 2'd3
  } lob_op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_ORDER_FULL = 3'd3,
    ST_LEVEL_FULL = 3'd4
  } lob_status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] order_id;
    logic        is_buy;
    logic [31:0] limit_price;
  } lob_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  order_count;
    logic [31:0] best_bid;
    logic        bid_valid;
    logic [31:0] best_ask;
    logic        ask_valid;
  } lob_rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic        buy;
    logic [31:0] price;
  } lob_slot_t;

  typedef struct packed {
    logic              en;
    logic              used;
    logic [OIDX_W-1:0] addr;
    lob_slot_t         data;
  } lob_slot_wr_t;

  typedef struct packed {
    logic              buy;
    logic [31:0]       price;
    logic [HELD_W-1:0] orders;
  } lob_lvl_t;

  typedef struct packed {
    logic              en;
    logic              used;
    logic [LIDX_W-1:0] addr;
    lob_lvl_t          data;
  } lob_lvl_wr_t;

endpackage
`default_nettype wire

>>> rtl/core/lob_slot_tab.sv
// Order table: synchronous memory of resting orders with per-slot used flags.
`default_nettype none
module lob_slot_tab (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lob_pkg::lob_slot_wr_t      wr,
  input  logic [lob_pkg::OIDX_W-1:0] rd_addr,
  output lob_pkg::lob_slot_t         rd_data,
  output logic                       rd_used
);
  import lob_pkg::*;

  lob_slot_t              mem [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] used_r;
  lob_slot_t              rd_data_r;
  logic                   rd_used_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.en) begin
      used_r[wr.addr] <= wr.used;
    end
    rd_used_r <= used_r[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign rd_used = rd_used_r;

endmodule
`default_nettype wire

>>> rtl/core/lob_lvl_tab.sv
// Price level table: synchronous memory of levels with per-level used flags.
`default_nettype none
module lob_lvl_tab (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lob_pkg::lob_lvl_wr_t       wr,
  input  logic [lob_pkg::LIDX_W-1:0] rd_addr,
  output lob_pkg::lob_lvl_t          rd_data,
  output logic                       rd_used
);
  import lob_pkg::*;

  lob_lvl_t               mem [LEVEL_SLOTS];
  logic [LEVEL_SLOTS-1:0] used_r;
  lob_lvl_t               rd_data_r;
  logic                   rd_used_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.en) begin
      used_r[wr.addr] <= wr.used;
    end
    rd_used_r <= used_r[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign rd_used = rd_used_r;

endmodule
`default_nettype wire

>>> rtl/core/limit_order_book_engine_core.sv
// Top level of the limit order book engine: request sequencer around two tables.
`default_nettype none
// A request is taken when start is high and busy is low; its result appears
// on out_rsp for exactly one cycle with out_valid high, and the receiver cannot
// stall it. Each request is worked by walking the two table memories one entry
// per cycle through their single read port: the order table is scanned once
// for the id and the first free slot, the level table once for the price level
// (twice for a modify, once for the removed level and once for the new one),
// and the level table once more for the best bid and best ask. Each table
// holds 64 entries. Lookups, and requests rejected after the order scan, skip
// the scan for the price level; busy stays high while a request is worked.
// Buy and sell levels are kept apart, an empty level is freed at once, and
// free entries are taken lowest index first. A new request may be started in
// the cycle in which the previous result is shown.
module limit_order_book_engine_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lob_pkg::lob_req_t in_req,
  output logic              out_valid,
  output lob_pkg::lob_rsp_t out_rsp
);
  import lob_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OSCAN, S_OCHK, S_LSCAN, S_REM, S_ADD, S_BSCAN, S_FIN
  } state_t;

  state_t            state_r;
  lob_req_t          req_r;
  lob_status_t       status_r;
  logic [HELD_W-1:0] held_r;

  // Scan pipeline: address issued from cnt_r, data compared in the following cycle.
  logic [SCAN_W-1:0] cnt_r;
  logic              pipe_vld_r;
  logic [SCAN_W-1:0] pipe_idx_r;

  // Order scan results.
  logic              ofound_r;
  logic [OIDX_W-1:0] oidx_r;
  logic              ofree_ok_r;
  logic [OIDX_W-1:0] ofree_r;

  // Level scan key and results.
  logic              add_phase_r;
  logic              key_buy_r;
  logic [31:0]       key_price_r;
  logic              lfound_r;
  logic [LIDX_W-1:0] lidx_r;
  logic [HELD_W-1:0] lcnt_r;
  logic              lfree_ok_r;
  logic [LIDX_W-1:0] lfree_r;

  // Best price accumulation.
  logic              bid_ok_r;
  logic [31:0]       bid_r;
  logic              ask_ok_r;
  logic [31:0]       ask_r;

  logic              out_valid_r;
  lob_rsp_t          out_rsp_r;

  lob_slot_wr_t      slot_wr;
  lob_slot_t         slot_rd;
  logic              slot_rd_used;
  lob_lvl_wr_t       lvl_wr;
  lob_lvl_t          lvl_rd;
  logic              lvl_rd_used;

  logic              o_issue;
  logic              l_issue;
  logic              o_last;
  logic              l_last;
  logic [HELD_W-1:0] lcnt_dec;

  lob_slot_tab u_slot (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (slot_wr),
    .rd_addr (cnt_r[OIDX_W-1:0]),
    .rd_data (slot_rd),
    .rd_used (slot_rd_used)
  );

  lob_lvl_tab u_lvl (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (lvl_wr),
    .rd_addr (cnt_r[LIDX_W-1:0]),
    .rd_data (lvl_rd),
    .rd_used (lvl_rd_used)
  );

  assign o_issue  = (state_r == S_OSCAN) && (cnt_r < SCAN_W'(ORDER_SLOTS));
  assign l_issue  = ((state_r == S_LSCAN) || (state_r == S_BSCAN)) &&
                    (cnt_r < SCAN_W'(LEVEL_SLOTS));
  assign o_last   = pipe_vld_r && (pipe_idx_r == SCAN_W'(ORDER_SLOTS - 1));
  assign l_last   = pipe_vld_r && (pipe_idx_r == SCAN_W'(LEVEL_SLOTS - 1));
  assign lcnt_dec = (lcnt_r != '0) ? (lcnt_r - HELD_W'(1)) : '0;

  // Table writes happen only in the remove and add states, never while a
  // scan of the same table is reading, so no forwarding is needed.
  always_comb begin
    slot_wr            = '0;
    lvl_wr             = '0;
    slot_wr.data.id    = req_r.order_id;
    slot_wr.data.buy   = key_buy_r;
    slot_wr.data.price = key_price_r;
    lvl_wr.data.buy    = key_buy_r;
    lvl_wr.data.price  = key_price_r;
    unique case (state_r)
      S_REM: begin
        slot_wr.en   = 1'b1;
        slot_wr.used = 1'b0;
        slot_wr.addr = oidx_r;
        lvl_wr.en          = lfound_r;
        lvl_wr.addr        = lidx_r;
        lvl_wr.data.orders = lcnt_dec;
        lvl_wr.used        = (lcnt_dec != '0);
      end
      S_ADD: begin
        if (lfound_r || lfree_ok_r) begin
          slot_wr.en   = 1'b1;
          slot_wr.used = 1'b1;
          slot_wr.addr = ofree_r;
          lvl_wr.en    = 1'b1;
          lvl_wr.used  = 1'b1;
          if (lfound_r) begin
            lvl_wr.addr        = lidx_r;
            lvl_wr.data.orders = lcnt_r + HELD_W'(1);
          end else begin
            lvl_wr.addr        = lfree_r;
            lvl_wr.data.orders = HELD_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      pipe_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pipe_vld_r  <= o_issue || l_issue;
      pipe_idx_r  <= cnt_r;
      if (o_issue || l_issue) begin
        cnt_r <= cnt_r + SCAN_W'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r      <= in_req;
            cnt_r      <= '0;
            pipe_vld_r <= 1'b0;
            ofound_r   <= 1'b0;
            ofree_ok_r <= 1'b0;
            state_r    <= S_OSCAN;
          end
        end

        S_OSCAN: begin
          if (pipe_vld_r) begin
            if (slot_rd_used && (slot_rd.id == req_r.order_id) && !ofound_r) begin
              ofound_r    <= 1'b1;
              oidx_r      <= pipe_idx_r[OIDX_W-1:0];
              key_buy_r   <= slot_rd.buy;
              key_price_r <= slot_rd.price;
            end
            if (!slot_rd_used && !ofree_ok_r) begin
              ofree_ok_r <= 1'b1;
              ofree_r    <= pipe_idx_r[OIDX_W-1:0];
            end
          end
          if (o_last) begin
            state_r <= S_OCHK;
          end
        end

        S_OCHK: begin
          cnt_r      <= '0;
          pipe_vld_r <= 1'b0;
          lfound_r   <= 1'b0;
          lfree_ok_r <= 1'b0;
          bid_ok_r   <= 1'b0;
          ask_ok_r   <= 1'b0;
          bid_r      <= '0;
          ask_r      <= '0;
          if (req_r.op == OP_ADD) begin
            if (ofound_r) begin
              status_r <= ST_DUPLICATE;
              state_r  <= S_BSCAN;
            end else if (!ofree_ok_r) begin
              status_r <= ST_ORDER_FULL;
              state_r  <= S_BSCAN;
            end else begin
              key_buy_r   <= req_r.is_buy;
              key_price_r <= req_r.limit_price;
              add_phase_r <= 1'b1;
              state_r     <= S_LSCAN;
            end
          end else if (!ofound_r) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_BSCAN;
          end else if (req_r.op == OP_LOOKUP) begin
            status_r <= ST_OK;
            state_r  <= S_BSCAN;
          end else begin
            // Cancel and modify first look up the level the order rests on.
            add_phase_r <= 1'b0;
            state_r     <= S_LSCAN;
          end
        end

        S_LSCAN: begin
          if (pipe_vld_r) begin
            if (lvl_rd_used && (lvl_rd.buy == key_buy_r) &&
                (lvl_rd.price == key_price_r) && !lfound_r) begin
              lfound_r <= 1'b1;
              lidx_r   <= pipe_idx_r[LIDX_W-1:0];
              lcnt_r   <= lvl_rd.orders;
            end
            if (!lvl_rd_used && !lfree_ok_r) begin
              lfree_ok_r <= 1'b1;
              lfree_r    <= pipe_idx_r[LIDX_W-1:0];
            end
          end
          if (l_last) begin
            state_r <= add_phase_r ? S_ADD : S_REM;
          end
        end

        S_REM: begin
          if (held_r != '0) begin
            held_r <= held_r - HELD_W'(1);
          end
          cnt_r      <= '0;
          pipe_vld_r <= 1'b0;
          if (req_r.op == OP_MODIFY) begin
            // The freed slot is the lowest free one unless a lower one was free.
            if (!(ofree_ok_r && (ofree_r < oidx_r))) begin
              ofree_r <= oidx_r;
            end
            ofree_ok_r  <= 1'b1;
            key_buy_r   <= req_r.is_buy;
            key_price_r <= req_r.limit_price;
            lfound_r    <= 1'b0;
            lfree_ok_r  <= 1'b0;
            add_phase_r <= 1'b1;
            state_r     <= S_LSCAN;
          end else begin
            status_r <= ST_OK;
            state_r  <= S_BSCAN;
          end
        end

        S_ADD: begin
          cnt_r      <= '0;
          pipe_vld_r <= 1'b0;
          bid_ok_r   <= 1'b0;
          ask_ok_r   <= 1'b0;
          bid_r      <= '0;
          ask_r      <= '0;
          if (lfound_r || lfree_ok_r) begin
            held_r   <= held_r + HELD_W'(1);
            status_r <= ST_OK;
          end else begin
            status_r <= ST_LEVEL_FULL;
          end
          state_r <= S_BSCAN;
        end

        S_BSCAN: begin
          if (pipe_vld_r && lvl_rd_used) begin
            if (lvl_rd.buy) begin
              if (!bid_ok_r || (lvl_rd.price > bid_r)) begin
                bid_r    <= lvl_rd.price;
                bid_ok_r <= 1'b1;
              end
            end else begin
              if (!ask_ok_r || (lvl_rd.price < ask_r)) begin
                ask_r    <= lvl_rd.price;
                ask_ok_r <= 1'b1;
              end
            end
          end
          if (l_last) begin
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          out_valid_r           <= 1'b1;
          out_rsp_r.status      <= status_r;
          out_rsp_r.order_count <= 7'(held_r);
          out_rsp_r.best_bid    <= bid_r;
          out_rsp_r.bid_valid   <= bid_ok_r;
          out_rsp_r.best_ask    <= ask_r;
          out_rsp_r.ask_valid   <= ask_ok_r;
          state_r               <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire
